// ===== hw/rtl/changed_cell_run_encoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Changed cell run encoder: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CHANGED_CELL_RUN_ENCODER_UNIT_MACROS_SVH
`define CHANGED_CELL_RUN_ENCODER_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define CCRE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Assertion that also holds across reset.
`define CCRE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/ccre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed cell run encoder package
// Shared widths, defaults and the result types passed between the modules.
// ----------------------------------------------------------------------------
package ccre_pkg;

  localparam int MAX_GRID_CELLS_DEF = 1048576;
  localparam int MAX_RUN_CELLS_DEF  = 65535;
  localparam int STATE_BITS_DEF     = 2;

  localparam int CELL_OUT_W  = 20;
  localparam int LEN_W       = 16;
  localparam int STATE_OUT_W = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CELL_OUT_W-1:0]  first_cell;
    logic [LEN_W-1:0]       cells;
    logic [STATE_OUT_W-1:0] state;
    logic                   final_of_item;
  } result_t;

  // Up to two results per cell; a single result always sits in slot a.
  typedef struct packed {
    logic    valid_a;
    logic    valid_b;
    result_t a;
    result_t b;
  } push_t;

endpackage

// ===== hw/rtl/ccre_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed cell run encoder: run tracker
// Counts cells, tracks the open run and forms the runs closed by each cell.
// ----------------------------------------------------------------------------
module ccre_core #(
  parameter int MAX_GRID_CELLS = ccre_pkg::MAX_GRID_CELLS_DEF,
  parameter int MAX_RUN_CELLS  = ccre_pkg::MAX_RUN_CELLS_DEF,
  parameter int STATE_BITS     = ccre_pkg::STATE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [ccre_pkg::STATE_OUT_W-1:0]   current_state,
  input  logic [ccre_pkg::STATE_OUT_W-1:0]   held_state,
  input  logic                               last_cell,
  output ccre_pkg::push_t                    push
);

  localparam int CELL_W  = $clog2(MAX_GRID_CELLS);
  localparam int STATE_W = (STATE_BITS < ccre_pkg::STATE_OUT_W) ?
                           STATE_BITS : ccre_pkg::STATE_OUT_W;
  localparam int LEN_W   = ccre_pkg::LEN_W;

  logic [CELL_W-1:0]  cell_counter, cell_counter_next;
  logic               run_open, run_open_next;
  logic [CELL_W-1:0]  run_start, run_start_next;
  logic [LEN_W-1:0]   run_length, run_length_next;
  logic [STATE_W-1:0] open_run_state, open_run_state_next;

  logic [STATE_W-1:0] cur, held;
  logic               differs, last, extend, close_a, close_b;
  logic               open_mid;
  logic [CELL_W-1:0]  start_mid;
  logic [LEN_W-1:0]   length_mid;
  logic [STATE_W-1:0] state_mid;
  ccre_pkg::result_t  res_a, res_b;

  always_comb begin
    cur     = current_state[STATE_W-1:0];
    held    = held_state[STATE_W-1:0];
    differs = (cur != held);
    // The top cell of the grid always ends the pass.
    last    = last_cell || (cell_counter == CELL_W'(MAX_GRID_CELLS - 1));
    extend  = run_open && differs && (cur == open_run_state) &&
              (run_length < LEN_W'(MAX_RUN_CELLS));
    close_a = run_open && !extend;

    open_mid   = run_open;
    start_mid  = run_start;
    length_mid = run_length;
    state_mid  = open_run_state;
    if (extend) begin
      length_mid = LEN_W'(run_length + 1'b1);
    end else if (differs) begin
      open_mid   = 1'b1;
      start_mid  = cell_counter;
      length_mid = LEN_W'(1);
      state_mid  = cur;
    end else begin
      open_mid   = 1'b0;
      length_mid = '0;
    end
    close_b = last && open_mid;

    res_a.first_cell    = ccre_pkg::CELL_OUT_W'(run_start);
    res_a.cells         = run_length;
    res_a.state         = ccre_pkg::STATE_OUT_W'(open_run_state);
    res_a.final_of_item = !close_b;

    res_b.first_cell    = ccre_pkg::CELL_OUT_W'(start_mid);
    res_b.cells         = length_mid;
    res_b.state         = ccre_pkg::STATE_OUT_W'(state_mid);
    res_b.final_of_item = 1'b1;

    // Pack a lone result into slot a.
    push.valid_a = accept && (close_a || close_b);
    push.valid_b = accept && close_a && close_b;
    push.a       = close_a ? res_a : res_b;
    push.b       = res_b;

    cell_counter_next   = cell_counter;
    run_open_next       = run_open;
    run_start_next      = run_start;
    run_length_next     = run_length;
    open_run_state_next = open_run_state;
    if (accept) begin
      cell_counter_next   = last ? '0 : CELL_W'(cell_counter + 1'b1);
      run_open_next       = open_mid && !last;
      run_start_next      = start_mid;
      run_length_next     = close_b ? '0 : length_mid;
      open_run_state_next = state_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_counter   <= '0;
      run_open       <= 1'b0;
      run_start      <= '0;
      run_length     <= '0;
      open_run_state <= '0;
    end else begin
      cell_counter   <= cell_counter_next;
      run_open       <= run_open_next;
      run_start      <= run_start_next;
      run_length     <= run_length_next;
      open_run_state <= open_run_state_next;
    end
  end

endmodule

// ===== hw/rtl/ccre_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed cell run encoder: result queue
// Small register queue taking up to two runs per cycle and giving one.
// ----------------------------------------------------------------------------
module ccre_queue (
  input  logic              clk,
  input  logic              rst,
  input  ccre_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              head_valid,
  output ccre_pkg::result_t head
);

  localparam int DEPTH   = ccre_pkg::QUEUE_DEPTH;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  ccre_pkg::result_t    entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [1:0]           push_n;
  logic                 do_pop;
  logic [PTR_W-1:0]     wr_ptr_b;

  always_comb begin
    push_n      = {1'b0, push.valid_a} + {1'b0, push.valid_b};
    do_pop      = pop && head_valid;
    wr_ptr_b    = PTR_W'(wr_ptr + 1'b1);
    wr_ptr_next = PTR_W'(wr_ptr + push_n);
    rd_ptr_next = do_pop ? PTR_W'(rd_ptr + 1'b1) : rd_ptr;
    count_next  = COUNT_W'(count + push_n - {{(COUNT_W-1){1'b0}}, do_pop});
  end

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  // Keep space for a cell that closes two runs.
  assign room       = (count <= COUNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid_a) begin
      entries[wr_ptr] <= push.a;
    end
    if (push.valid_b) begin
      entries[wr_ptr_b] <= push.b;
    end
  end

endmodule

// ===== hw/rtl/changed_cell_run_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed cell run encoder
// Turns a stream of grid cells into runs of changed cells with one state.
// ----------------------------------------------------------------------------
// Takes one grid cell per clock and numbers the cells itself from zero; a
// cell on tlast, or the top cell of the grid, ends the pass and the count
// starts again. Runs leave on the master side one per transfer, first cell
// index, length and state, with tlast on the last run a cell caused. The run
// tracker decides in the cycle a cell is taken, and its runs are in the
// output queue in the cycle after. A cell that closes two runs needs two
// output transfers, so the sustained rate is one cell per clock while each
// cell closes at most one run and the output is taken each cycle; the
// four-entry result queue sets how far a stalled output lets cells keep
// coming (input ready stays high while two or fewer runs are queued).
module changed_cell_run_encoder_unit #(
  parameter int MAX_GRID_CELLS = ccre_pkg::MAX_GRID_CELLS_DEF,
  parameter int MAX_RUN_CELLS  = ccre_pkg::MAX_RUN_CELLS_DEF,
  parameter int STATE_BITS     = ccre_pkg::STATE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] current_state, [3:2] held_state, [7:4] zero
  input  logic [ccre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // last_cell
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [19:0] run_first_cell, [35:20] run_cells, [37:36] run_state, [39:38] zero
  output logic [ccre_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // final_of_item
  output logic                               m_axis_tlast
);

  localparam int SW = ccre_pkg::STATE_OUT_W;

  logic              accept;
  ccre_pkg::push_t   push;
  ccre_pkg::result_t head;

  assign accept = s_axis_tvalid && s_axis_tready;

  ccre_core #(
    .MAX_GRID_CELLS (MAX_GRID_CELLS),
    .MAX_RUN_CELLS  (MAX_RUN_CELLS),
    .STATE_BITS     (STATE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .current_state (s_axis_tdata[SW-1:0]),
    .held_state    (s_axis_tdata[2*SW-1:SW]),
    .last_cell     (s_axis_tlast),
    .push          (push)
  );

  ccre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (m_axis_tready),
    .room       (s_axis_tready),
    .head_valid (m_axis_tvalid),
    .head       (head)
  );

  assign m_axis_tdata = ccre_pkg::OUT_TDATA_W'({head.state, head.cells, head.first_cell});
  assign m_axis_tlast = head.final_of_item;

endmodule

// ===== hw/rtl/ccre_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Changed cell run encoder: port checker
// Watches the top level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "changed_cell_run_encoder_unit_macros.svh"

module ccre_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ccre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ccre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // Output queue comes up empty.
  `CCRE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid)

  // A stalled run holds until taken.
  `CCRE_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Every run has at least one cell.
  `CCRE_ASSERT(a_run_nonempty, clk, rst, m_axis_tvalid |-> m_axis_tdata[35:20] != 16'd0)

  // Input ready drops only after a cell transfer filled the queue.
  `CCRE_ASSERT(a_ready_drop, clk, rst, $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))

endmodule

bind changed_cell_run_encoder_unit ccre_checker u_ccre_checker (.*);
